// File: hw/rtl/btlpm_pkg.sv
package btlpm_pkg;

  localparam int unsigned NODE_COUNT = 4096;
  localparam int unsigned IDX_W      = $clog2(NODE_COUNT);
  localparam int unsigned FREE_W     = IDX_W + 1;
  localparam int unsigned LEVELS     = 32;
  localparam int unsigned LVL_W      = $clog2(LEVELS + 1);
  localparam int unsigned PORT_W     = 9;

  // command codes carried in tuser
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_MISS = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  // port field: bit 8 set means the node carries no next hop
  localparam logic [PORT_W-1:0] NO_HOP = PORT_W'(256);

  typedef struct packed {
    logic [IDX_W-1:0]  right;
    logic [IDX_W-1:0]  left;
    logic [PORT_W-1:0] port;
  } node_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    node_t            data;
  } wr_req_t;

endpackage

// File: hw/rtl/btlpm_node_ram.sv
module btlpm_node_ram (
  input  logic                          clk_i,
  input  btlpm_pkg::wr_req_t            wr_i,
  input  logic [btlpm_pkg::IDX_W-1:0]   raddr_i,
  output btlpm_pkg::node_t              rdata_o
);
  import btlpm_pkg::*;

  node_t mem_q [NODE_COUNT];
  node_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/binary_trie_longest_prefix_match.sv
// Longest-prefix match engine over a uni-bit binary trie of IPv4 routes. A
// request with tuser 0 inserts the top prefix_length bits of address with the
// given next hop (only the first insert of a prefix sets its hop; length 0 is
// ignored, lengths above 32 count as 32); a request with tuser 1 looks up the
// address and returns the deepest next hop on its path, or status miss. Nodes
// come from a pool of NODE_COUNT - 1 entries (node 0 is reserved); when it
// runs out an insert stops with status pool full and keeps the nodes it made.
// The walk visits one trie level per clock through the write port and the
// registered read port of the node memory: an insert walks L levels for
// length L, a lookup walks until its path ends, at most 32 levels. The next
// request is taken only in idle, after the walk of the last one has finished.
// The node memory needs no clearing after reset.
module binary_trie_longest_prefix_match (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // address[31:0], prefix_length[37:32], next_hop[45:38]
  input  logic [0:0]  s_axis_tuser,   // cmd[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // hop_result[7:0]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);
  import btlpm_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic              state_q, state_d;
  logic              cmd_q;
  logic [31:0]       addr_q;
  logic [5:0]        len_q;
  logic [7:0]        hop_q;
  logic [LVL_W-1:0]  lvl_q, lvl_d;
  logic              root_q, root_d;
  logic              use_rd_q, use_rd_d;
  logic              dirty_q, dirty_d;
  logic [IDX_W-1:0]  cur_q, cur_d;
  node_t             entry_q, entry_d;
  logic              found_q, found_d;
  logic [7:0]        best_q, best_d;
  logic [IDX_W-1:0]  root_l_q, root_l_d;
  logic [IDX_W-1:0]  root_r_q, root_r_d;
  logic [FREE_W-1:0] free_q, free_d;
  logic              out_valid_q;
  logic [1:0]        out_status_q;
  logic [7:0]        out_hop_q;

  wr_req_t           wr;
  logic [IDX_W-1:0]  raddr;
  node_t             rdata;

  node_t             entry;
  node_t             upd;
  logic              lvl_bit;
  logic [IDX_W-1:0]  child;
  logic              pool_full;
  logic              fin;
  logic              go;
  logic [1:0]        fin_status;
  logic [7:0]        fin_hop;
  logic              accept;
  logic [5:0]        in_len;

  btlpm_node_ram u_node_ram (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_len        = (s_axis_tdata[37:32] > 6'd32) ? 6'd32 : s_axis_tdata[37:32];

  assign entry     = use_rd_q ? rdata : entry_q;
  // bit 31 - level of the address
  assign lvl_bit   = addr_q[~lvl_q[4:0]];
  assign child     = root_q ? (lvl_bit ? root_r_q : root_l_q)
                            : (lvl_bit ? entry.right : entry.left);
  assign pool_full = (free_q == FREE_W'(NODE_COUNT));

  always_comb begin
    fin        = 1'b0;
    fin_status = STATUS_OK;
    fin_hop    = 8'd0;
    wr         = '0;
    raddr      = child;
    upd        = entry;
    lvl_d      = lvl_q;
    root_d     = root_q;
    use_rd_d   = use_rd_q;
    dirty_d    = dirty_q;
    cur_d      = cur_q;
    entry_d    = entry;
    found_d    = found_q;
    best_d     = best_q;
    root_l_d   = root_l_q;
    root_r_d   = root_r_q;
    free_d     = free_q;

    if (cmd_q == CMD_INSERT) begin
      if (lvl_q == LVL_W'(len_q)) begin
        fin = 1'b1;
        if (upd.port[PORT_W-1]) begin
          upd.port = {1'b0, hop_q};
        end
        wr.we   = !root_q && (dirty_q || entry.port[PORT_W-1]);
        wr.addr = cur_q;
        wr.data = upd;
      end else if (child != '0) begin
        wr.we    = dirty_q && !root_q;
        wr.addr  = cur_q;
        wr.data  = entry;
        cur_d    = child;
        root_d   = 1'b0;
        use_rd_d = 1'b1;
        dirty_d  = 1'b0;
        lvl_d    = lvl_q + LVL_W'(1);
      end else if (pool_full) begin
        fin        = 1'b1;
        fin_status = STATUS_FULL;
        wr.we      = dirty_q && !root_q;
        wr.addr    = cur_q;
        wr.data    = entry;
      end else begin
        // link a fresh node; its own entry stays in entry_q until it is left
        if (lvl_bit) begin
          upd.right = free_q[IDX_W-1:0];
        end else begin
          upd.left = free_q[IDX_W-1:0];
        end
        if (root_q) begin
          if (lvl_bit) begin
            root_r_d = free_q[IDX_W-1:0];
          end else begin
            root_l_d = free_q[IDX_W-1:0];
          end
        end else begin
          wr.we   = 1'b1;
          wr.addr = cur_q;
          wr.data = upd;
        end
        free_d        = free_q + FREE_W'(1);
        cur_d         = free_q[IDX_W-1:0];
        entry_d       = '0;
        entry_d.port  = NO_HOP;
        root_d        = 1'b0;
        use_rd_d      = 1'b0;
        dirty_d       = 1'b1;
        lvl_d         = lvl_q + LVL_W'(1);
      end
    end else begin
      if (!root_q && !entry.port[PORT_W-1]) begin
        found_d = 1'b1;
        best_d  = entry.port[7:0];
      end
      if (lvl_q == LVL_W'(LEVELS) || child == '0) begin
        fin        = 1'b1;
        fin_status = found_d ? STATUS_OK : STATUS_MISS;
        fin_hop    = found_d ? best_d : 8'd0;
      end else begin
        cur_d    = child;
        root_d   = 1'b0;
        use_rd_d = 1'b1;
        lvl_d    = lvl_q + LVL_W'(1);
      end
    end

    if (state_q != ST_WALK) begin
      fin   = 1'b0;
      wr.we = 1'b0;
    end
  end

  // a finished walk waits while the previous result is still held
  assign go = (state_q == ST_WALK) && !(fin && out_valid_q && !m_axis_tready);

  always_comb begin
    state_d = state_q;
    if (accept) begin
      state_d = ST_WALK;
    end else if (go && fin) begin
      state_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      root_l_q <= '0;
      root_r_q <= '0;
      free_q   <= FREE_W'(1);
    end else begin
      state_q <= state_d;
      if (go) begin
        root_l_q <= root_l_d;
        root_r_q <= root_r_d;
        free_q   <= free_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= s_axis_tuser[0];
      addr_q   <= s_axis_tdata[31:0];
      len_q    <= in_len;
      hop_q    <= s_axis_tdata[45:38];
      lvl_q    <= '0;
      root_q   <= 1'b1;
      use_rd_q <= 1'b0;
      dirty_q  <= 1'b0;
      found_q  <= 1'b0;
      best_q   <= 8'd0;
    end else if (go) begin
      lvl_q    <= lvl_d;
      root_q   <= root_d;
      use_rd_q <= use_rd_d;
      dirty_q  <= dirty_d;
      cur_q    <= cur_d;
      entry_q  <= entry_d;
      found_q  <= found_d;
      best_q   <= best_d;
    end else if (state_q == ST_WALK) begin
      // hold the node entry while the memory read port moves on
      entry_q  <= entry;
      use_rd_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (go && fin) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && fin) begin
      out_status_q <= fin_status;
      out_hop_q    <= fin_hop;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_hop_q;
  assign m_axis_tuser  = out_status_q;

  a_no_write_to_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.we |-> (wr.addr != '0))
    else $error("write to reserved node zero");

  a_free_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_q != '0) && (free_q <= FREE_W'(NODE_COUNT)))
    else $error("free node counter out of range");

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (lvl_q <= LVL_W'(LEVELS)))
    else $error("walk went past the last level");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_status_q)
                                         && $stable(out_hop_q)))
    else $error("pending result overwritten");

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
  import btlpm_pkg::*;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] hop;
  } lpm_result_t;

  // shadow copy of the route trie, one expected result per accepted request
  class route_scoreboard;
    logic [PORT_W-1:0] port_tbl [NODE_COUNT];
    logic [IDX_W-1:0]  left_tbl [NODE_COUNT];
    logic [IDX_W-1:0]  right_tbl [NODE_COUNT];
    logic [IDX_W-1:0]  root_kid [2];
    int unsigned       free_idx;
    lpm_result_t       pending[$];
    int                errors;

    function new();
      root_kid[0] = '0;
      root_kid[1] = '0;
      free_idx = 1;
      errors = 0;
    endfunction

    function bit pool_exhausted();
      return free_idx >= NODE_COUNT;
    endfunction

    function void note(logic cmd, logic [31:0] addr, logic [5:0] len, logic [7:0] hop);
      lpm_result_t res;
      logic [IDX_W-1:0] node;
      logic [IDX_W-1:0] kid;
      logic b;
      int depth;
      res.status = STATUS_OK;
      res.hop = 8'h00;
      node = '0;
      if (cmd == CMD_INSERT) begin
        depth = (len > 6'd32) ? 32 : int'(len);
        for (int lvl = 0; lvl < depth; lvl++) begin
          b = addr[31-lvl];
          kid = (lvl == 0) ? root_kid[b] : (b ? right_tbl[node] : left_tbl[node]);
          if (kid == '0) begin
            if (free_idx >= NODE_COUNT) begin
              res.status = STATUS_FULL;
              break;
            end
            kid = IDX_W'(free_idx);
            free_idx++;
            port_tbl[kid] = NO_HOP;
            left_tbl[kid] = '0;
            right_tbl[kid] = '0;
            if (lvl == 0) root_kid[b] = kid;
            else if (b) right_tbl[node] = kid;
            else left_tbl[node] = kid;
          end
          node = kid;
          // only the first insert of a prefix sets its hop
          if (lvl == depth - 1 && port_tbl[node][PORT_W-1])
            port_tbl[node] = {1'b0, hop};
        end
      end else begin
        res.status = STATUS_MISS;
        for (int lvl = 0; lvl < LEVELS; lvl++) begin
          b = addr[31-lvl];
          kid = (lvl == 0) ? root_kid[b] : (b ? right_tbl[node] : left_tbl[node]);
          if (kid == '0) break;
          node = kid;
          if (!port_tbl[node][PORT_W-1]) begin
            res.status = STATUS_OK;
            res.hop = port_tbl[node][7:0];
          end
        end
      end
      pending.push_back(res);
    endfunction

    function void check(logic [1:0] status, logic [7:0] hop);
      lpm_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d hop %0d",
                 $time, status, hop);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (status !== want.status) begin
        $display("%0t: status mismatch, expected %0d, got %0d", $time, want.status, status);
        errors++;
      end
      if (hop !== want.hop) begin
        $display("%0t: hop mismatch, expected %0d, got %0d", $time, want.hop, hop);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  route_scoreboard book = new();

  logic [31:0] route_addr [64];
  logic [5:0]  route_len [64];
  bit          calm_tx;
  int          tx_count;
  bit          long_hold_go;
  bit          long_hold_done;

  binary_trie_longest_prefix_match uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(input logic cmd, input logic [31:0] addr,
                              input logic [5:0] len, input logic [7:0] hop);
    int gap;
    if (tx_count % 64 == 0) calm_tx = ($urandom_range(0, 3) == 0);
    tx_count++;
    gap = calm_tx ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, hop, len, addr};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    book.note(cmd, addr, len, hop);
    @(negedge clk_i);
  endtask

  task automatic mixed_request();
    int r;
    int k;
    logic [31:0] a;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 63);
    if (r < 45) begin
      send_request(CMD_INSERT, route_addr[k], route_len[k], 8'($urandom));
    end else if (r < 55) begin
      send_request(CMD_INSERT, $urandom, 6'($urandom_range(0, 63)), 8'($urandom));
    end else if (r < 90) begin
      // stay on a known route, scramble the bits below it
      a = route_addr[k] ^ ($urandom >> route_len[k]);
      send_request(CMD_LOOKUP, a, 6'($urandom), 8'($urandom));
    end else begin
      send_request(CMD_LOOKUP, $urandom, 6'($urandom), 8'($urandom));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) book.check(m_axis_tuser, m_axis_tdata);
  end

  initial begin : result_sink
    int stall_left;
    int cyc;
    bit calm_rx;
    stall_left = 0;
    cyc = 0;
    calm_rx = 1'b0;
    long_hold_done = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc % 200 == 0) calm_rx = ($urandom_range(0, 3) == 0);
      if (long_hold_go && !long_hold_done) begin
        stall_left = 500;
        long_hold_done = 1'b1;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm_rx) stall_left = pick_gap();
      end
    end
  end

  initial begin : watchdog
    #10000000;
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin : stimulus
    int n;
    int r;
    int plen;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    calm_tx = 1'b0;
    tx_count = 0;
    long_hold_go = 1'b0;

    // route set with nested prefixes so lookups walk deep shared paths
    for (int k = 0; k < 64; k++) begin
      r = $urandom_range(0, 99);
      if (k > 0 && r < 35) begin
        plen = (route_len[k-1] > 6'd32) ? 32 : int'(route_len[k-1]);
        plen = plen + $urandom_range(1, 8);
        route_len[k] = (plen > 32) ? 6'd32 : 6'(plen);
        route_addr[k] = route_addr[k-1] ^ ($urandom >> route_len[k-1]);
      end else if (r < 45) begin
        route_len[k] = ($urandom_range(0, 3) == 0) ? 6'd0 : 6'($urandom_range(33, 63));
        route_addr[k] = $urandom;
      end else begin
        route_len[k] = (r < 80) ? 6'($urandom_range(8, 24)) : 6'($urandom_range(1, 32));
        route_addr[k] = $urandom;
      end
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty trie, zero length, clamping, repeats, nesting
    send_request(CMD_LOOKUP, 32'h0000_0000, 6'd0, 8'h00);
    send_request(CMD_INSERT, 32'hFFFF_FFFF, 6'd0, 8'h05);
    send_request(CMD_LOOKUP, 32'hFFFF_FFFF, 6'd63, 8'hFF);
    send_request(CMD_INSERT, 32'h0A00_0000, 6'd8, 8'h07);
    send_request(CMD_INSERT, 32'h0A00_0000, 6'd8, 8'h09);
    send_request(CMD_LOOKUP, 32'h0A01_0203, 6'd0, 8'h00);
    send_request(CMD_LOOKUP, 32'h0B00_0000, 6'd0, 8'h00);
    send_request(CMD_INSERT, 32'h0000_0000, 6'd1, 8'h00);
    send_request(CMD_INSERT, 32'h8000_0000, 6'd1, 8'hFF);
    send_request(CMD_INSERT, 32'hFFFF_FFFF, 6'd32, 8'hAA);
    send_request(CMD_INSERT, 32'hFFFF_FFFF, 6'd63, 8'h55);
    send_request(CMD_INSERT, 32'h0000_0000, 6'd33, 8'h11);
    send_request(CMD_LOOKUP, 32'h0000_0000, 6'd0, 8'h00);
    send_request(CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0, 8'h00);
    send_request(CMD_LOOKUP, 32'hFFFF_FFFE, 6'd0, 8'h00);
    send_request(CMD_LOOKUP, 32'h7FFF_FFFF, 6'd0, 8'h00);
    send_request(CMD_INSERT, 32'hC0A8_0000, 6'd16, 8'h42);
    send_request(CMD_INSERT, 32'hC0A8_0100, 6'd24, 8'h43);
    send_request(CMD_LOOKUP, 32'hC0A8_0105, 6'd0, 8'h00);
    send_request(CMD_LOOKUP, 32'hC0A8_FF01, 6'd0, 8'h00);
    send_request(CMD_INSERT, 32'hF0FF_FFFF, 6'd4, 8'h3C);
    send_request(CMD_LOOKUP, 32'hF000_0000, 6'd0, 8'h00);

    // route churn on a partly filled pool
    for (n = 0; n < 600; n++) begin
      if (n == 300) long_hold_go = 1'b1;
      mixed_request();
    end

    // long random routes until the node pool runs dry
    n = 0;
    while (n < 250 || (!book.pool_exhausted() && n < 1200)) begin
      r = $urandom_range(0, 99);
      if (r < 70)
        send_request(CMD_INSERT, $urandom, 6'($urandom_range(20, 32)), 8'($urandom));
      else if (r < 75)
        send_request(CMD_INSERT, $urandom, 6'($urandom_range(33, 63)), 8'($urandom));
      else
        mixed_request();
      n++;
    end

    // full pool: known routes still resolve, new ones stop
    for (n = 0; n < 200; n++) mixed_request();

    s_axis_tvalid <= 1'b0;
    while (book.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (book.errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/btlpm_pkg.sv
hw/rtl/btlpm_node_ram.sv
hw/rtl/binary_trie_longest_prefix_match.sv
tb/sv/tb_top.sv
